// ===== rtl/ttvp_pkg.sv =====
`default_nettype none

package ttvp_pkg;

  // Field widths.
  localparam int ANG_W     = 15;
  localparam int SPEED_W   = 13;
  localparam int RATE_W    = 12;
  localparam int RATE3_W   = 14;
  localparam int A_W       = 22;
  localparam int WIND_W    = 11;
  localparam int VEL_W     = 10;
  localparam int IDX_OUT_W = 3;
  localparam int TRIG_W    = 32;

  // Projected points per item.
  localparam int NUM_POINTS = 6;
  localparam int IDX_W      = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

  // Angles in 1/64 degree.
  localparam logic [ANG_W-1:0] FULL_TURN    = 15'd23040;
  localparam logic [ANG_W-1:0] QUARTER_TURN = 15'd5760;
  localparam logic [ANG_W-1:0] EIGHTH_TURN  = 15'd2880;

  // Knots to m/s is 463/900.
  localparam logic [A_W-1:0] KNOT_NUM = 22'd463;

  // Series evaluation in Q30.
  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
  localparam logic [18:0] RAD_PER_UNIT = 19'd292818;
  localparam int HORNER_STEPS = 4;

  // Floor division of a 30-bit value by d as (n * M) >> K, M = ceil(2^K / d).
  localparam int K_SIN [HORNER_STEPS] = '{37, 36, 35, 33};
  localparam int K_COS [HORNER_STEPS] = '{36, 35, 34, 31};
  localparam logic [31:0] M_SIN [HORNER_STEPS] = '{
    32'(((64'd1 << 37) + 64'd71) / 64'd72),
    32'(((64'd1 << 36) + 64'd41) / 64'd42),
    32'(((64'd1 << 35) + 64'd19) / 64'd20),
    32'(((64'd1 << 33) + 64'd5) / 64'd6)
  };
  localparam logic [31:0] M_COS [HORNER_STEPS] = '{
    32'(((64'd1 << 36) + 64'd55) / 64'd56),
    32'(((64'd1 << 35) + 64'd29) / 64'd30),
    32'(((64'd1 << 34) + 64'd11) / 64'd12),
    32'(((64'd1 << 31) + 64'd1) / 64'd2)
  };

  // Pipeline depths of the back end.
  localparam int TRIG_LAT = 13;
  localparam int COMP_LAT = 5;
  localparam int PIPE_LAT = TRIG_LAT + COMP_LAT;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WIND_NORTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIND_EAST  = 1'd1;

  typedef struct packed {
    logic [ANG_W-1:0]          base;
    logic signed [RATE3_W-1:0] rate3;
    logic [A_W-1:0]            speed_scaled;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/ttvp_front.sv =====
`default_nettype none

module ttvp_front import ttvp_pkg::*; (
  input  logic                     start,
  input  logic [ANG_W-1:0]         in_heading_angle,
  input  logic [ANG_W-1:0]         in_course_angle,
  input  logic [SPEED_W-1:0]       in_ground_speed,
  input  logic signed [RATE_W-1:0] in_turn_rate,
  input  logic                     q_full,
  output logic                     busy,
  output logic                     push,
  output entry_t                   push_data
);

  logic [ANG_W-1:0]          hsel;
  logic signed [RATE3_W-1:0] rate_ext;

  // A zero heading is unknown; the course stands in unless it is zero too.
  assign hsel = (in_heading_angle == '0 && in_course_angle != '0) ?
                in_course_angle : in_heading_angle;
  assign rate_ext = RATE3_W'(in_turn_rate);

  assign push_data.base  = (hsel >= FULL_TURN) ? hsel - FULL_TURN : hsel;
  assign push_data.rate3 = rate_ext + (rate_ext <<< 1);
  assign push_data.speed_scaled = A_W'(in_ground_speed) * KNOT_NUM;

  assign busy = q_full;
  assign push = start && !q_full;

endmodule

`default_nettype wire

// ===== rtl/ttvp_queue.sv =====
`default_nettype none

module ttvp_queue import ttvp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output logic   full,
  output logic   valid,
  output entry_t head
);

  entry_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r;
  logic [QPTR_W-1:0] rd_r;
  logic [QCNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  assign head  = mem_r[rd_r];
  assign valid = (cnt_r != '0);
  assign full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

// ===== rtl/ttvp_trig.sv =====
`default_nettype none

module ttvp_trig import ttvp_pkg::*; (
  input  logic                     clk,
  input  logic [ANG_W-1:0]         angle,
  output logic signed [TRIG_W-1:0] sin_val,
  output logic signed [TRIG_W-1:0] cos_val
);

  // The ts and tc fields hold the running Horner terms; after a product
  // stage they hold the product that the next stage divides.
  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [1:0]  q;
    logic        sw;
    logic [30:0] ts;
    logic [30:0] tc;
  } hst_t;

  logic [1:0]  q1_r;
  logic [11:0] r1_r;
  logic        sw1_r;
  logic [1:0]  q2_r;
  logic [29:0] x2_r;
  logic        sw2_r;
  hst_t        hs_r [2*HORNER_STEPS+1];
  logic [30:0] s12_r;
  logic [30:0] c12_r;
  logic [1:0]  q12_r;
  logic        sw12_r;

  logic [1:0]  q_c;
  logic [12:0] rq_c;
  logic [30:0] xprod;
  logic [59:0] sq;
  logic [60:0] fin;

  logic [60:0] ps [HORNER_STEPS];
  logic [60:0] pc [HORNER_STEPS];
  logic [61:0] ds [HORNER_STEPS];
  logic [61:0] dc [HORNER_STEPS];
  logic [61:0] qs [HORNER_STEPS];
  logic [61:0] qc [HORNER_STEPS];

  // Quadrant and octant reduction.
  always_comb begin
    priority if (angle >= 3 * QUARTER_TURN) begin
      q_c  = 2'd3;
      rq_c = 13'(angle - 3 * QUARTER_TURN);
    end else if (angle >= 2 * QUARTER_TURN) begin
      q_c  = 2'd2;
      rq_c = 13'(angle - 2 * QUARTER_TURN);
    end else if (angle >= QUARTER_TURN) begin
      q_c  = 2'd1;
      rq_c = 13'(angle - QUARTER_TURN);
    end else begin
      q_c  = 2'd0;
      rq_c = 13'(angle);
    end
  end

  always_ff @(posedge clk) begin
    q1_r  <= q_c;
    sw1_r <= (rq_c > 13'(EIGHTH_TURN));
    r1_r  <= (rq_c > 13'(EIGHTH_TURN)) ? 12'(13'(QUARTER_TURN) - rq_c) : 12'(rq_c);
  end

  assign xprod = 31'(r1_r) * 31'(RAD_PER_UNIT);

  always_ff @(posedge clk) begin
    x2_r  <= xprod[29:0];
    q2_r  <= q1_r;
    sw2_r <= sw1_r;
  end

  assign sq = 60'(x2_r) * 60'(x2_r);

  always_comb begin
    for (int k = 0; k < HORNER_STEPS; k++) begin
      ps[k] = 61'(hs_r[2*k].x2) * 61'(hs_r[2*k].ts);
      pc[k] = 61'(hs_r[2*k].x2) * 61'(hs_r[2*k].tc);
      ds[k] = 62'(hs_r[2*k+1].ts[29:0]) * 62'(M_SIN[k]);
      dc[k] = 62'(hs_r[2*k+1].tc[29:0]) * 62'(M_COS[k]);
      qs[k] = ds[k] >> K_SIN[k];
      qc[k] = dc[k] >> K_COS[k];
    end
  end

  always_ff @(posedge clk) begin
    hs_r[0].x  <= x2_r;
    hs_r[0].x2 <= sq[59:30];
    hs_r[0].q  <= q2_r;
    hs_r[0].sw <= sw2_r;
    hs_r[0].ts <= Q30_ONE;
    hs_r[0].tc <= Q30_ONE;
    for (int k = 0; k < HORNER_STEPS; k++) begin
      hs_r[2*k+1].x  <= hs_r[2*k].x;
      hs_r[2*k+1].x2 <= hs_r[2*k].x2;
      hs_r[2*k+1].q  <= hs_r[2*k].q;
      hs_r[2*k+1].sw <= hs_r[2*k].sw;
      hs_r[2*k+1].ts <= ps[k][60:30];
      hs_r[2*k+1].tc <= pc[k][60:30];
      hs_r[2*k+2].x  <= hs_r[2*k+1].x;
      hs_r[2*k+2].x2 <= hs_r[2*k+1].x2;
      hs_r[2*k+2].q  <= hs_r[2*k+1].q;
      hs_r[2*k+2].sw <= hs_r[2*k+1].sw;
      hs_r[2*k+2].ts <= Q30_ONE - qs[k][30:0];
      hs_r[2*k+2].tc <= Q30_ONE - qc[k][30:0];
    end
  end

  assign fin = 61'(hs_r[2*HORNER_STEPS].x) * 61'(hs_r[2*HORNER_STEPS].ts);

  always_ff @(posedge clk) begin
    s12_r  <= fin[60:30];
    c12_r  <= hs_r[2*HORNER_STEPS].tc;
    q12_r  <= hs_r[2*HORNER_STEPS].q;
    sw12_r <= hs_r[2*HORNER_STEPS].sw;
  end

  // Past the octant boundary sine and cosine trade places, then the
  // quadrant rotates the pair and sets the signs.
  always_ff @(posedge clk) begin
    logic signed [TRIG_W-1:0] sv;
    logic signed [TRIG_W-1:0] cv;
    sv = $signed({1'b0, sw12_r ? c12_r : s12_r});
    cv = $signed({1'b0, sw12_r ? s12_r : c12_r});
    unique case (q12_r)
      2'd0: begin
        sin_val <= sv;
        cos_val <= cv;
      end
      2'd1: begin
        sin_val <= cv;
        cos_val <= -sv;
      end
      2'd2: begin
        sin_val <= -sv;
        cos_val <= -cv;
      end
      default: begin
        sin_val <= -cv;
        cos_val <= sv;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/ttvp_comp.sv =====
`default_nettype none

module ttvp_comp import ttvp_pkg::*; (
  input  logic                     clk,
  input  logic signed [TRIG_W-1:0] trig,
  input  logic [A_W-1:0]           speed_scaled,
  input  logic signed [WIND_W-1:0] wind,
  output logic signed [VEL_W-1:0]  velocity
);

  localparam int NUM_W = 55;
  localparam int U_W   = 19;
  localparam int RCP_K = 27;
  localparam logic signed [NUM_W-1:0] WIND_SCALE = 55'sd900;
  // Half of 16 * 900 * 2^30, which is 225 * 2^36.
  localparam logic [NUM_W-1:0] HALF_DEN = 55'd225 << 35;
  localparam logic [U_W:0] RCP_225 = 20'(((64'd1 << RCP_K) + 64'd224) / 64'd225);

  logic signed [NUM_W-1:0] prod_r;
  logic signed [NUM_W-1:0] num_r;
  logic [U_W-1:0]          u_r;
  logic                    neg3_r;
  logic [11:0]             q_r;
  logic                    neg4_r;

  logic signed [NUM_W-1:0] wind_term;
  logic [NUM_W-1:0]        mag;
  logic [NUM_W-1:0]        sum;
  logic [38:0]             rcp;

  always_ff @(posedge clk) begin
    prod_r <= NUM_W'($signed({1'b0, speed_scaled})) * NUM_W'(trig);
  end

  assign wind_term = (NUM_W'(wind) * WIND_SCALE) <<< 30;

  always_ff @(posedge clk) begin
    num_r <= prod_r + wind_term;
  end

  // Round half away from zero: bias the magnitude, then divide.
  assign mag = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign sum = mag + HALF_DEN;

  always_ff @(posedge clk) begin
    u_r    <= sum[NUM_W-1:36];
    neg3_r <= num_r[NUM_W-1];
  end

  assign rcp = 39'(u_r) * 39'(RCP_225);

  always_ff @(posedge clk) begin
    q_r    <= rcp[38:RCP_K];
    neg4_r <= neg3_r;
  end

  always_ff @(posedge clk) begin
    if (neg4_r) begin
      velocity <= (q_r > 12'd512) ? -10'sd512 : VEL_W'(-$signed({1'b0, q_r}));
    end else begin
      velocity <= (q_r > 12'd511) ? 10'sd511 : VEL_W'(q_r);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ttvp_back.sv =====
`default_nettype none

module ttvp_back import ttvp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  entry_t                   q_head,
  output logic                     q_pop,
  input  logic signed [WIND_W-1:0] wind_north,
  input  logic signed [WIND_W-1:0] wind_east,
  output logic                     out_valid,
  output logic [IDX_OUT_W-1:0]     out_point_index,
  output logic signed [VEL_W-1:0]  out_velocity_north,
  output logic signed [VEL_W-1:0]  out_velocity_east,
  output logic                     out_last_point
);

  function automatic logic [ANG_W-1:0] wrap_angle(input logic signed [16:0] s);
    logic signed [16:0] full;
    logic signed [16:0] t;
    full = $signed({2'b00, FULL_TURN});
    if (s < 0) t = s + full;
    else if (s >= full) t = s - full;
    else t = s;
    return t[ANG_W-1:0];
  endfunction

  logic                      act_r, act_nxt;
  logic [ANG_W-1:0]          h_r, h_nxt;
  logic signed [RATE3_W-1:0] rate3_r, rate3_nxt;
  logic [A_W-1:0]            a_r, a_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic                      last_now;
  logic                      load;

  logic [PIPE_LAT:1]   v_r;
  logic [IDX_W-1:0]    tidx_r  [1:PIPE_LAT];
  logic                tlast_r [1:PIPE_LAT];
  logic [A_W-1:0]      ta_r    [1:TRIG_LAT];

  logic signed [TRIG_W-1:0] sin_v;
  logic signed [TRIG_W-1:0] cos_v;

  assign last_now = act_r && (idx_r == IDX_W'(NUM_POINTS - 1));
  // The next item is taken on the cycle that the current one issues its
  // final point, so points flow without a gap.
  assign load  = q_valid && (!act_r || last_now);
  assign q_pop = load;

  always_comb begin
    act_nxt   = act_r;
    h_nxt     = h_r;
    rate3_nxt = rate3_r;
    a_nxt     = a_r;
    idx_nxt   = idx_r;
    if (load) begin
      act_nxt   = 1'b1;
      h_nxt     = wrap_angle($signed({2'b00, q_head.base}) + 17'(q_head.rate3));
      rate3_nxt = q_head.rate3;
      a_nxt     = q_head.speed_scaled;
      idx_nxt   = '0;
    end else if (last_now) begin
      act_nxt = 1'b0;
    end else if (act_r) begin
      h_nxt   = wrap_angle($signed({2'b00, h_r}) + 17'(rate3_r));
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
    end
    h_r     <= h_nxt;
    rate3_r <= rate3_nxt;
    a_r     <= a_nxt;
    idx_r   <= idx_nxt;
  end

  // Item tags travel beside the arithmetic.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[PIPE_LAT-1:1], act_r};
    end
    tidx_r[1]  <= idx_r;
    tlast_r[1] <= last_now;
    ta_r[1]    <= a_r;
    for (int j = 2; j <= PIPE_LAT; j++) begin
      tidx_r[j]  <= tidx_r[j-1];
      tlast_r[j] <= tlast_r[j-1];
    end
    for (int j = 2; j <= TRIG_LAT; j++) begin
      ta_r[j] <= ta_r[j-1];
    end
  end

  ttvp_trig u_trig (
    .clk     (clk),
    .angle   (h_r),
    .sin_val (sin_v),
    .cos_val (cos_v)
  );

  ttvp_comp u_comp_north (
    .clk          (clk),
    .trig         (cos_v),
    .speed_scaled (ta_r[TRIG_LAT]),
    .wind         (wind_north),
    .velocity     (out_velocity_north)
  );

  ttvp_comp u_comp_east (
    .clk          (clk),
    .trig         (sin_v),
    .speed_scaled (ta_r[TRIG_LAT]),
    .wind         (wind_east),
    .velocity     (out_velocity_east)
  );

  assign out_valid       = v_r[PIPE_LAT];
  assign out_point_index = IDX_OUT_W'(tidx_r[PIPE_LAT]);
  assign out_last_point  = tlast_r[PIPE_LAT];

  a_idx_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r && !last_now) |=> (act_r && idx_r == $past(idx_r) + 1'b1))
    else $error("point counter did not advance");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[PIPE_LAT] && tlast_r[PIPE_LAT]) |->
      (tidx_r[PIPE_LAT] == IDX_W'(NUM_POINTS - 1)))
    else $error("last point carries wrong index");

endmodule

`default_nettype wire

// ===== rtl/turning_track_velocity_projector.sv =====
// Turning track velocity projector.
// Input channel: an item (heading, course, ground speed, turn rate) is taken
// at a rising edge with start high and busy low. Each item yields six
// results, one per projected point three seconds apart, each shown for one
// cycle with out_valid high; the sixth has out_last_point set.
// The back end issues the points of an item one per cycle into its
// 18-stage trig and rounding pipeline, so they reach the outputs one per
// cycle, and it takes the next waiting item from the queue in the cycle
// that the current one issues its final point. A two-entry queue between
// front and back takes items early; busy rises only when it is full.
// The results cannot be held off, so the pipeline never stalls.
// Configuration: cfg_we writes wind_north (index 0) or wind_east (index 1);
// write only while the block is idle.
// Reset (synchronous, rst_n low) empties the queue and the pipeline and sets
// both wind registers to zero.
`default_nettype none

module turning_track_velocity_projector import ttvp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [ANG_W-1:0]         in_heading_angle,
  input  logic [ANG_W-1:0]         in_course_angle,
  input  logic [SPEED_W-1:0]       in_ground_speed,
  input  logic signed [RATE_W-1:0] in_turn_rate,
  output logic                     out_valid,
  output logic [IDX_OUT_W-1:0]     out_point_index,
  output logic signed [VEL_W-1:0]  out_velocity_north,
  output logic signed [VEL_W-1:0]  out_velocity_east,
  output logic                     out_last_point,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [WIND_W-1:0]        cfg_wdata
);

  logic signed [WIND_W-1:0] wind_north_r;
  logic signed [WIND_W-1:0] wind_east_r;

  logic   q_full;
  logic   q_valid;
  logic   push;
  logic   pop;
  entry_t push_data;
  entry_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wind_north_r <= '0;
      wind_east_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIND_NORTH: wind_north_r <= $signed(cfg_wdata);
        REG_WIND_EAST:  wind_east_r  <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  ttvp_front u_front (
    .start            (start),
    .in_heading_angle (in_heading_angle),
    .in_course_angle  (in_course_angle),
    .in_ground_speed  (in_ground_speed),
    .in_turn_rate     (in_turn_rate),
    .q_full           (q_full),
    .busy             (busy),
    .push             (push),
    .push_data        (push_data)
  );

  ttvp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (head)
  );

  ttvp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_head             (head),
    .q_pop              (pop),
    .wind_north         (wind_north_r),
    .wind_east          (wind_east_r),
    .out_valid          (out_valid),
    .out_point_index    (out_point_index),
    .out_velocity_north (out_velocity_north),
    .out_velocity_east  (out_velocity_east),
    .out_last_point     (out_last_point)
  );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ttvp_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam longint unsigned Q30 = 64'd1 << 30;
  localparam longint unsigned ROUND_DEN = 64'd16 * 64'd900 * (64'd1 << 30);

  typedef struct {
    logic [IDX_OUT_W-1:0]    idx;
    logic signed [VEL_W-1:0] vn;
    logic signed [VEL_W-1:0] ve;
    logic                    last;
  } point_t;

  typedef struct {
    logic [ANG_W-1:0]         heading;
    logic [ANG_W-1:0]         course;
    logic [SPEED_W-1:0]       speed;
    logic signed [RATE_W-1:0] rate;
    bit                       known;
    int                       vn;
    int                       ve;
  } row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [ANG_W-1:0]         in_heading_angle;
  logic [ANG_W-1:0]         in_course_angle;
  logic [SPEED_W-1:0]       in_ground_speed;
  logic signed [RATE_W-1:0] in_turn_rate;
  logic                     out_valid;
  logic [IDX_OUT_W-1:0]     out_point_index;
  logic signed [VEL_W-1:0]  out_velocity_north;
  logic signed [VEL_W-1:0]  out_velocity_east;
  logic                     out_last_point;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [WIND_W-1:0]        cfg_wdata;

  point_t pending_points[$];
  longint wind_n;
  longint wind_e;
  int     n_errors;
  int     idle_cycles;
  bit     took_item;

  turning_track_velocity_projector u_top (
    .clk, .rst_n, .start, .busy,
    .in_heading_angle, .in_course_angle, .in_ground_speed, .in_turn_rate,
    .out_valid, .out_point_index, .out_velocity_north, .out_velocity_east,
    .out_last_point, .cfg_we, .cfg_index, .cfg_wdata
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sine and cosine of an angle within one octant, unsigned Q30.
  function automatic void octant_sin_cos(input longint unsigned r,
                                         output longint unsigned s,
                                         output longint unsigned c);
    longint unsigned x, x2, t;
    x  = r * 64'd292818;
    x2 = (x * x) >> 30;
    t = Q30 - x2 / 72;
    t = Q30 - ((x2 * t) >> 30) / 42;
    t = Q30 - ((x2 * t) >> 30) / 20;
    t = Q30 - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    t = Q30 - x2 / 56;
    t = Q30 - ((x2 * t) >> 30) / 30;
    t = Q30 - ((x2 * t) >> 30) / 12;
    t = Q30 - ((x2 * t) >> 30) / 2;
    c = t;
  endfunction

  function automatic void heading_sin_cos(input longint unsigned a,
                                          output longint sn, output longint cs);
    longint unsigned q, r, s, c;
    q = a / 5760;
    r = a % 5760;
    if (r <= 2880) octant_sin_cos(r, s, c);
    else octant_sin_cos(5760 - r, c, s);
    case (q & 3)
      0: begin sn = s;  cs = c;  end
      1: begin sn = c;  cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  // Speed times trig plus wind, rounded half away from zero and saturated.
  function automatic logic signed [VEL_W-1:0] speed_to_ms(longint spd, longint trig,
                                                          longint wind);
    longint num, v;
    longint unsigned mag, q;
    num = spd * 463 * trig + wind * 900 * longint'(Q30);
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag + ROUND_DEN / 2) / ROUND_DEN;
    if (q > 1024) q = 1024;
    v = (num < 0) ? -longint'(q) : longint'(q);
    if (v > 511) v = 511;
    if (v < -512) v = -512;
    return v[VEL_W-1:0];
  endfunction

  function automatic void project_track(logic [ANG_W-1:0] heading,
                                        logic [ANG_W-1:0] course,
                                        logic [SPEED_W-1:0] spd,
                                        logic signed [RATE_W-1:0] rate);
    longint base, h, sn, cs;
    point_t p;
    base = (heading == 0 && course != 0) ? course : heading;
    base = base % 23040;
    for (int i = 0; i < NUM_POINTS; i++) begin
      h = (base + longint'(rate) * 3 * (i + 1)) % 23040;
      if (h < 0) h += 23040;
      heading_sin_cos(h, sn, cs);
      p.idx  = i[IDX_OUT_W-1:0];
      p.vn   = speed_to_ms(spd, cs, wind_n);
      p.ve   = speed_to_ms(spd, sn, wind_e);
      p.last = (i == NUM_POINTS - 1);
      pending_points.push_back(p);
    end
  endfunction

  // Called at a rising edge; returns at the edge that accepts the item.
  task automatic send_track(row_t it, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_heading_angle <= it.heading;
    in_course_angle  <= it.course;
    in_ground_speed  <= it.speed;
    in_turn_rate     <= it.rate;
    do @(posedge clk); while (busy);
    took_item = 1'b1;
    if (it.known) begin
      for (int i = 0; i < NUM_POINTS; i++)
        pending_points.push_back('{i[IDX_OUT_W-1:0], it.vn[VEL_W-1:0],
                                   it.ve[VEL_W-1:0], i == NUM_POINTS - 1});
    end else begin
      project_track(it.heading, it.course, it.speed, it.rate);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_wind(logic [CFG_IDX_W-1:0] idx, logic signed [WIND_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WIND_NORTH) wind_n = val;
    else wind_e = val;
  endtask

  function automatic row_t random_track();
    row_t it;
    int pick;
    it.known = 1'b0;
    pick = $urandom_range(0, 9);
    it.heading = (pick == 0) ? '0 : (pick == 1) ? ANG_W'($urandom)
                                                : ANG_W'($urandom_range(0, 23039));
    it.course = ($urandom_range(0, 5) == 0) ? '0 : ANG_W'($urandom);
    it.speed = ($urandom_range(0, 3) == 0) ? SPEED_W'($urandom_range(8000, 8191))
                                           : SPEED_W'($urandom);
    it.rate = ($urandom_range(0, 4) == 0) ? RATE_W'($urandom_range(0, 1) ? 2047 : -2048)
                                          : RATE_W'($urandom);
    return it;
  endfunction

  always @(posedge clk) begin
    point_t want;
    if (out_valid) begin
      if (pending_points.size() == 0) begin
        $error("unexpected point index %0d", out_point_index);
        n_errors++;
      end else begin
        want = pending_points.pop_front();
        if (out_point_index !== want.idx) begin
          $error("point_index expected %0d got %0d", want.idx, out_point_index);
          n_errors++;
        end
        if (out_velocity_north !== want.vn) begin
          $error("velocity_north expected %0d got %0d", want.vn, out_velocity_north);
          n_errors++;
        end
        if (out_velocity_east !== want.ve) begin
          $error("velocity_east expected %0d got %0d", want.ve, out_velocity_east);
          n_errors++;
        end
        if (out_last_point !== want.last) begin
          $error("last_point expected %0d got %0d", want.last, out_last_point);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on cycles where neither side moves an item.
  always @(posedge clk) begin
    if (out_valid || took_item) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    took_item = 1'b0;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  row_t directed[] = '{
    '{15'd0,     15'd0,     13'd0,    12'sd0,     1'b1, 0, 0},
    '{15'd23039, 15'd0,     13'd0,    12'sd2047,  1'b1, 0, 0},
    '{15'd0,     15'd23039, 13'd0,    -12'sd2048, 1'b1, 0, 0},
    '{15'd0,     15'd0,     13'd8191, 12'sd0,     1'b0, 0, 0},
    '{15'd0,     15'd100,   13'd8191, 12'sd0,     1'b0, 0, 0},
    '{15'd32767, 15'd32767, 13'd8191, 12'sd0,     1'b0, 0, 0},
    '{15'd23040, 15'd5,     13'd8191, 12'sd0,     1'b0, 0, 0},
    '{15'd2880,  15'd0,     13'd8191, 12'sd0,     1'b0, 0, 0},
    '{15'd5760,  15'd0,     13'd8191, 12'sd0,     1'b0, 0, 0},
    '{15'd11520, 15'd0,     13'd8191, 12'sd0,     1'b0, 0, 0},
    '{15'd17280, 15'd0,     13'd8191, 12'sd0,     1'b0, 0, 0},
    '{15'd1,     15'd0,     13'd8191, 12'sd2047,  1'b0, 0, 0},
    '{15'd23039, 15'd0,     13'd8191, -12'sd2048, 1'b0, 0, 0},
    '{15'd100,   15'd0,     13'd1,    12'sd0,     1'b0, 0, 0},
    '{15'd3000,  15'd0,     13'd16,   -12'sd1,    1'b0, 0, 0},
    '{15'd0,     15'd23039, 13'd8191, 12'sd2047,  1'b0, 0, 0}
  };

  initial begin
    logic signed [WIND_W-1:0] winds[4][2];
    rst_n = 1'b0;
    start = 1'b0;
    in_heading_angle = '0;
    in_course_angle  = '0;
    in_ground_speed  = '0;
    in_turn_rate     = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    n_errors = 0;
    idle_cycles = 0;
    took_item = 1'b0;
    wind_n = 0;
    wind_e = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_track(directed[i], $urandom_range(0, 14));
    drain();

    winds[0] = '{-11'sd1024, 11'sd1023};
    winds[1] = '{11'sd1023, -11'sd1024};
    winds[2] = '{WIND_W'($urandom), WIND_W'($urandom)};
    winds[3] = '{11'sd0, 11'sd0};
    for (int ph = 0; ph < 4; ph++) begin
      write_wind(REG_WIND_NORTH, winds[ph][0]);
      write_wind(REG_WIND_EAST, winds[ph][1]);
      // The middle of each phase runs back to back to keep the queue full.
      for (int n = 0; n < 92; n++)
        send_track(random_track(), (n > 30 && n < 50) ? 0 : $urandom_range(0, 14));
      drain();
    end

    if (n_errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
